@@ design/tqm_pkg.sv @@
// Shared constants, codes and control structs for the team queue manager.
package tqm_pkg;

   localparam int TEAMS      = 16;
   localparam int MEMBER_IDS = 1024;   // a power of two: the table index is the low id bits
   localparam int TEAM_DEPTH = 16;

   localparam int CMD_W     = 2;
   localparam int MEMBER_W  = 10;
   localparam int TEAM_IN_W = 4;
   localparam int STATUS_W  = 2;

   localparam int TW         = (TEAMS > 1) ? $clog2(TEAMS) : 1;
   localparam int OCW        = $clog2(TEAMS + 1);
   localparam int DW         = (TEAM_DEPTH > 1) ? $clog2(TEAM_DEPTH) : 1;
   localparam int CW         = $clog2(TEAM_DEPTH + 1);
   localparam int MID_W      = $clog2(MEMBER_IDS);
   localparam int FIFO_WORDS = TEAMS * TEAM_DEPTH;
   localparam int FA_W       = (FIFO_WORDS > 1) ? $clog2(FIFO_WORDS) : 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ASSIGN = 2'd0,
      CMD_ENQ    = 2'd1,
      CMD_DEQ    = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_DATA  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic sweep;
      logic accept;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic out_free;
   } dp_stat_type;

endpackage

@@ design/tqm_ctrl.sv @@
// Controller state machine: membership clearing pass, item acceptance and commit.
module tqm_ctrl import tqm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output dp_cmd_type  ctl,
   input  dp_stat_type stat
);

   typedef enum logic [1:0] {
      S_SWEEP,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_SWEEP: begin
            ctl.sweep = 1'b1;
            if (stat.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            ctl.accept = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // The result register must be free or emptying this cycle.
            ctl.commit = stat.out_free;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_SWEEP;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/tqm_datapath.sv @@
// Datapath: membership table, team FIFO memory, per-team pointers, order ring, result register.
module tqm_datapath import tqm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           ctl,
   output dp_stat_type          stat,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [MEMBER_W-1:0]  req_member_id,
   input  logic [TEAM_IN_W-1:0] req_team_id,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [MEMBER_W-1:0]  rsp_out_member
);

   function automatic logic [MID_W-1:0] slot_of(input logic [MEMBER_W-1:0] m);
      slot_of = MID_W'(m);
   endfunction

   function automatic logic [DW-1:0] fifo_next(input logic [DW-1:0] p);
      fifo_next = (int'(p) == TEAM_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [TW-1:0] order_next(input logic [TW-1:0] p);
      order_next = (int'(p) == TEAMS - 1) ? '0 : p + 1'b1;
   endfunction

   cmd_type               cmd_ff;
   logic [MEMBER_W-1:0]   member_ff;
   logic [TEAM_IN_W-1:0]  team_in_ff;
   logic [TW-1:0]         member_team_ff;
   logic [MEMBER_W-1:0]   fifo_rdata_ff;
   logic [MID_W-1:0]      sweep_cnt_ff;

   logic [TW-1:0]         membership_mem [MEMBER_IDS];
   logic [MEMBER_W-1:0]   fifo_mem [FIFO_WORDS];

   logic [DW-1:0]         head_ff [TEAMS];
   logic [DW-1:0]         tail_ff [TEAMS];
   logic [CW-1:0]         count_ff [TEAMS];
   logic [TEAMS-1:0]      waiting_ff;
   logic [TW-1:0]         order_mem_ff [TEAMS];
   logic [TW-1:0]         ohead_ff;
   logic [TW-1:0]         otail_ff;
   logic [OCW-1:0]        ocount_ff;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [MEMBER_W-1:0]   rsp_member_ff;

   logic [TW-1:0]         deq_team;
   logic                  deq_empty;
   logic [TW-1:0]         team_sel;
   logic                  enq_full;
   logic                  assign_ok;
   logic [FA_W-1:0]       deq_addr;
   logic [FA_W-1:0]       enq_addr;
   logic                  commit_assign;
   logic                  commit_enq;
   logic                  commit_deq;
   logic                  commit_clear;
   logic                  join_order;
   logic                  last_out;
   status_type            status_in;
   logic [MEMBER_W-1:0]   member_in;

   // Dequeue side is taken from registers only, so it is the same at accept and commit.
   assign deq_team  = (ocount_ff != '0) ? order_mem_ff[ohead_ff] : '0;
   assign deq_empty = (ocount_ff == '0) || (count_ff[deq_team] == '0);
   assign team_sel  = (cmd_ff == CMD_ENQ) ? member_team_ff : deq_team;
   assign enq_full  = (int'(count_ff[team_sel]) >= TEAM_DEPTH);
   assign assign_ok = (int'(team_in_ff) < TEAMS);
   assign last_out  = (count_ff[team_sel] == CW'(1));

   assign deq_addr = FA_W'(deq_team) * FA_W'(TEAM_DEPTH) + FA_W'(head_ff[deq_team]);
   assign enq_addr = FA_W'(team_sel) * FA_W'(TEAM_DEPTH) + FA_W'(tail_ff[team_sel]);

   assign commit_assign = ctl.commit && (cmd_ff == CMD_ASSIGN) && assign_ok;
   assign commit_enq    = ctl.commit && (cmd_ff == CMD_ENQ) && !enq_full;
   assign commit_deq    = ctl.commit && (cmd_ff == CMD_DEQ) && !deq_empty;
   assign commit_clear  = ctl.commit && (cmd_ff == CMD_CLEAR);
   assign join_order    = commit_enq && !waiting_ff[team_sel] && (int'(ocount_ff) < TEAMS);

   always_comb begin
      status_in = ST_DONE;
      member_in = '0;
      case (cmd_ff)
         CMD_ENQ: begin
            status_in = enq_full ? ST_FULL : ST_DONE;
         end
         CMD_DEQ: begin
            if (deq_empty) begin
               status_in = ST_EMPTY;
            end else begin
               status_in = ST_DATA;
               member_in = fifo_rdata_ff;
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff     <= cmd_type'(req_cmd);
         member_ff  <= req_member_id;
         team_in_ff <= req_team_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else if (ctl.sweep) begin
         sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.sweep) begin
         membership_mem[sweep_cnt_ff] <= '0;
      end else if (commit_assign) begin
         membership_mem[slot_of(member_ff)] <= TW'(team_in_ff);
      end
      if (ctl.accept) begin
         member_team_ff <= membership_mem[slot_of(req_member_id)];
      end
   end

   always_ff @(posedge clock) begin
      if (commit_enq) begin
         fifo_mem[enq_addr] <= member_ff;
      end
      if (ctl.accept) begin
         fifo_rdata_ff <= fifo_mem[deq_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (join_order) begin
         order_mem_ff[otail_ff] <= team_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || commit_clear) begin
         for (int i = 0; i < TEAMS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         waiting_ff <= '0;
         ohead_ff   <= '0;
         otail_ff   <= '0;
         ocount_ff  <= '0;
      end else begin
         if (commit_enq) begin
            tail_ff[team_sel]  <= fifo_next(tail_ff[team_sel]);
            count_ff[team_sel] <= count_ff[team_sel] + 1'b1;
            if (join_order) begin
               waiting_ff[team_sel] <= 1'b1;
               otail_ff             <= order_next(otail_ff);
               ocount_ff            <= ocount_ff + 1'b1;
            end
         end
         if (commit_deq) begin
            head_ff[team_sel]  <= fifo_next(head_ff[team_sel]);
            count_ff[team_sel] <= count_ff[team_sel] - 1'b1;
            // A team whose last member leaves drops out of the service order.
            if (last_out) begin
               waiting_ff[team_sel] <= 1'b0;
               ohead_ff             <= order_next(ohead_ff);
               ocount_ff            <= ocount_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_status_ff <= status_in;
         rsp_member_ff <= member_in;
      end
   end

   assign stat.sweep_done = (int'(sweep_cnt_ff) == MEMBER_IDS - 1);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_member = rsp_member_ff;

endmodule

@@ design/team_queue_manager_core.sv @@
// Each item is accepted in S_IDLE and committed in S_EXEC: the result register loads at commit,
// and the block takes no new item until the last one is committed.
// This is set by the read at acceptance and the write at commit of the team FIFO memory
// and the membership table. A commit waits while the result register is full and stalled.
// After reset the membership table is cleared one entry a cycle, all MEMBER_IDS entries,
// with req_stall high until the pass ends; queues and pointers clear at once.
module team_queue_manager_core import tqm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [MEMBER_W-1:0]  req_member_id,
   input  logic [TEAM_IN_W-1:0] req_team_id,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [MEMBER_W-1:0]  rsp_out_member
);

   dp_cmd_type  ctl;
   dp_stat_type stat;

   tqm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .ctl       (ctl),
      .stat      (stat)
   );

   tqm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .stat           (stat),
      .req_cmd        (req_cmd),
      .req_member_id  (req_member_id),
      .req_team_id    (req_team_id),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_out_member (rsp_out_member)
   );

`ifndef SYNTHESIS
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled in the cycle after an item was accepted");

   a_commit_has_room: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> (!rsp_valid || !rsp_stall))
      else $error("commit would overwrite a stalled result");

   a_result_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctl.commit))
      else $error("result appeared without a commit");

   a_sweep_blocks_input: assert property (@(posedge clock) disable iff (reset)
      ctl.sweep |-> req_stall)
      else $error("item could be accepted during the membership clearing pass");
`endif

endmodule
